// ----- rtl/bfbp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfbp_pkg: shared types and constants of the best-fit buffer pool
// Pool and pending stack sizes, field widths, operation and status codes, and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bfbp_pkg;

  localparam int POOL_SLOTS    = 16;
  localparam int PENDING_DEPTH = 16;

  localparam int HANDLE_W = 16;
  localparam int SIZE_W   = 24;
  localparam int ENTRY_W  = HANDLE_W + SIZE_W;
  localparam int COUNT_W  = 5;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam int IDX_W  = $clog2(POOL_SLOTS);
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int PIDX_W = $clog2(PENDING_DEPTH);
  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RETURN  = 2'd1,
    KIND_DEFER   = 2'd2,
    KIND_FLUSH   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_PEND_FULL = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the input transaction, clear scan state
    logic scan;      // walk the slot store, one slot a cycle
    logic fl_put;    // move the stack top into the pool
    logic exec;      // apply the operation, form status
    logic load_out;  // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;    // last slot evaluated this cycle
    logic stack_empty;
    logic stack_last;   // exactly one pending entry left
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/best_fit_buffer_pool.sv -----
// ----------------------------------------------------------------------------
// best_fit_buffer_pool: best-fit free-buffer pool with a pending stack
// Acquire, return, defer and flush transactions on a valid/ready channel,
// one result transaction for each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries kind, buffer_handle, buffer_size
//   and request_size. Output channel (out_valid/out_ready) carries status,
//   got_handle, got_size, free_count and pending_count, one result per input.
//   One transaction is in flight at a time; in_ready is high only while idle.
//   Steps from acceptance to out_valid:
//     acquire         the slot RAM is read one slot a cycle for the
//                     best-fit scan, then the update
//     return, defer   the update alone
//     flush           for each of the N pending entries a pending RAM
//                     read, then a slot write; then the update
//   Reset (rst, synchronous) empties the pool and the pending stack at once;
//   no clearing pass runs, and the block accepts input right after reset.
//   A stalled receiver holds the result in the output register; the next
//   transaction may be accepted and worked on meanwhile, and its result
//   waits until the held one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_buffer_pool (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bfbp_pkg::KIND_W-1:0]   kind,
  input  wire logic [bfbp_pkg::HANDLE_W-1:0] buffer_handle,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]   buffer_size,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]   request_size,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bfbp_pkg::STATUS_W-1:0]      status,
  output logic [bfbp_pkg::HANDLE_W-1:0]      got_handle,
  output logic [bfbp_pkg::SIZE_W-1:0]        got_size,
  output logic [bfbp_pkg::COUNT_W-1:0]       free_count,
  output logic [bfbp_pkg::COUNT_W-1:0]       pending_count
);

  // Command and status bundles between the sequencer and the datapath
  bfbp_pkg::cmd_t  cmd;
  bfbp_pkg::stat_t stat;

  // Sequencer: owns in_ready and out_valid
  bfbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: slot and pending RAMs, scan, result register
  bfbp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .buffer_handle (buffer_handle),
    .buffer_size   (buffer_size),
    .request_size  (request_size),
    .status        (status),
    .got_handle    (got_handle),
    .got_size      (got_size),
    .free_count    (free_count),
    .pending_count (pending_count)
  );

endmodule

`default_nettype wire

// ----- rtl/bfbp_ram.sv -----
// ----------------------------------------------------------------------------
// bfbp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/bfbp_datapath.sv -----
// ----------------------------------------------------------------------------
// bfbp_datapath: slot store, pending stack and best-fit scan
// Holds slot valid bits and counts, scans the slot RAM for the best fit, and
// forms the result register under controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbp_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bfbp_pkg::cmd_t                   cmd,
  output bfbp_pkg::stat_t                       stat,
  input  wire logic [bfbp_pkg::KIND_W-1:0]      kind,
  input  wire logic [bfbp_pkg::HANDLE_W-1:0]    buffer_handle,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]      buffer_size,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]      request_size,
  output logic      [bfbp_pkg::STATUS_W-1:0]    status,
  output logic      [bfbp_pkg::HANDLE_W-1:0]    got_handle,
  output logic      [bfbp_pkg::SIZE_W-1:0]      got_size,
  output logic      [bfbp_pkg::COUNT_W-1:0]     free_count,
  output logic      [bfbp_pkg::COUNT_W-1:0]     pending_count
);

  // Latched transaction
  bfbp_pkg::kind_t                   kind_q;
  logic [bfbp_pkg::HANDLE_W-1:0]     handle_q;
  logic [bfbp_pkg::SIZE_W-1:0]       size_q;
  logic [bfbp_pkg::SIZE_W-1:0]       req_q;

  // Pool and stack bookkeeping
  logic [bfbp_pkg::POOL_SLOTS-1:0]   valid_q;
  logic [bfbp_pkg::CNT_W-1:0]        pool_cnt;
  logic [bfbp_pkg::PCNT_W-1:0]       stack_cnt;
  logic                              drop_q;

  // Scan state
  logic [bfbp_pkg::IDX_W-1:0]        scan_idx;
  logic                              issue_done;
  logic                              eval_vld;
  logic [bfbp_pkg::IDX_W-1:0]        eval_idx;
  logic                              found;
  logic [bfbp_pkg::IDX_W-1:0]        best_idx;
  logic [bfbp_pkg::HANDLE_W-1:0]     best_handle;
  logic [bfbp_pkg::SIZE_W-1:0]       best_size;

  // Operation result
  bfbp_pkg::status_t                 res_status;
  logic [bfbp_pkg::HANDLE_W-1:0]     res_handle;
  logic [bfbp_pkg::SIZE_W-1:0]       res_size;

  // Memory ports
  logic [bfbp_pkg::ENTRY_W-1:0]      slot_rdata;
  logic [bfbp_pkg::ENTRY_W-1:0]      slot_wdata;
  logic                              slot_we;
  logic [bfbp_pkg::ENTRY_W-1:0]      pend_rdata;
  logic                              pend_we;
  logic [bfbp_pkg::PIDX_W-1:0]       pend_waddr;
  logic [bfbp_pkg::PIDX_W-1:0]       pend_raddr;

  logic [bfbp_pkg::HANDLE_W-1:0]     rd_handle;
  logic [bfbp_pkg::SIZE_W-1:0]       rd_size;
  logic [bfbp_pkg::IDX_W-1:0]        free_idx;
  logic                              pool_full;
  logic                              stack_full;
  logic                              put_ok;
  logic                              acq_hit;

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = bfbp_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = bfbp_pkg::IDX_W'(i);
      end
    end
  end

  assign pool_full  = (pool_cnt == bfbp_pkg::CNT_W'(bfbp_pkg::POOL_SLOTS));
  assign stack_full = (stack_cnt == bfbp_pkg::PCNT_W'(bfbp_pkg::PENDING_DEPTH));
  assign rd_handle  = slot_rdata[bfbp_pkg::ENTRY_W-1:bfbp_pkg::SIZE_W];
  assign rd_size    = slot_rdata[bfbp_pkg::SIZE_W-1:0];
  assign acq_hit    = (kind_q == bfbp_pkg::KIND_ACQUIRE) && found;

  // A return or a flush entry lands in the lowest free slot
  assign put_ok  = !pool_full &&
                   ((cmd.exec && kind_q == bfbp_pkg::KIND_RETURN) || cmd.fl_put);
  assign slot_we = put_ok;
  assign slot_wdata = cmd.fl_put ? pend_rdata : {handle_q, size_q};

  assign pend_we    = cmd.exec && kind_q == bfbp_pkg::KIND_DEFER && !stack_full;
  assign pend_waddr = bfbp_pkg::PIDX_W'(stack_cnt);
  assign pend_raddr = bfbp_pkg::PIDX_W'(stack_cnt - bfbp_pkg::PCNT_W'(1));

  bfbp_ram #(
    .WIDTH (bfbp_pkg::ENTRY_W),
    .DEPTH (bfbp_pkg::POOL_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (free_idx),
    .wdata (slot_wdata),
    .raddr (scan_idx),
    .rdata (slot_rdata)
  );

  bfbp_ram #(
    .WIDTH (bfbp_pkg::ENTRY_W),
    .DEPTH (bfbp_pkg::PENDING_DEPTH)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata ({handle_q, size_q}),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  assign stat.scan_done   = eval_vld && (eval_idx == bfbp_pkg::IDX_W'(bfbp_pkg::POOL_SLOTS - 1));
  assign stat.stack_empty = (stack_cnt == '0);
  assign stat.stack_last  = (stack_cnt == bfbp_pkg::PCNT_W'(1));

  // Transaction latch, best-fit candidate and result (no reset needed)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q   <= bfbp_pkg::kind_t'(kind);
      handle_q <= buffer_handle;
      size_q   <= buffer_size;
      req_q    <= request_size;
      found    <= 1'b0;
    end else if (eval_vld && valid_q[eval_idx] && rd_size >= req_q &&
                 (!found || rd_size < best_size)) begin
      found       <= 1'b1;
      best_idx    <= eval_idx;
      best_handle <= rd_handle;
      best_size   <= rd_size;
    end

    if (cmd.exec) begin
      res_handle <= acq_hit ? best_handle : '0;
      res_size   <= acq_hit ? best_size : '0;
      unique case (kind_q)
        bfbp_pkg::KIND_ACQUIRE: begin
          res_status <= found ? bfbp_pkg::ST_OK : bfbp_pkg::ST_NO_FIT;
        end
        bfbp_pkg::KIND_RETURN: begin
          res_status <= pool_full ? bfbp_pkg::ST_POOL_FULL : bfbp_pkg::ST_OK;
        end
        bfbp_pkg::KIND_DEFER: begin
          res_status <= stack_full ? bfbp_pkg::ST_PEND_FULL : bfbp_pkg::ST_OK;
        end
        bfbp_pkg::KIND_FLUSH: begin
          res_status <= drop_q ? bfbp_pkg::ST_POOL_FULL : bfbp_pkg::ST_OK;
        end
        default: res_status <= bfbp_pkg::ST_OK;
      endcase
    end

    if (cmd.load_out) begin
      status        <= res_status;
      got_handle    <= res_handle;
      got_size      <= res_size;
      free_count    <= bfbp_pkg::COUNT_W'(pool_cnt);
      pending_count <= bfbp_pkg::COUNT_W'(stack_cnt);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= '0;
      pool_cnt   <= '0;
      stack_cnt  <= '0;
      drop_q     <= 1'b0;
      scan_idx   <= '0;
      issue_done <= 1'b0;
      eval_vld   <= 1'b0;
      eval_idx   <= '0;
    end else begin
      if (cmd.capture) begin
        scan_idx   <= '0;
        issue_done <= 1'b0;
        eval_vld   <= 1'b0;
        drop_q     <= 1'b0;
      end else if (cmd.scan && !issue_done) begin
        scan_idx   <= bfbp_pkg::IDX_W'(scan_idx + 1'b1);
        issue_done <= (scan_idx == bfbp_pkg::IDX_W'(bfbp_pkg::POOL_SLOTS - 1));
        eval_vld   <= 1'b1;
        eval_idx   <= scan_idx;
      end else begin
        eval_vld <= 1'b0;
      end

      // Release the chosen slot on a successful acquire
      if (cmd.exec && acq_hit) begin
        valid_q[best_idx] <= 1'b0;
        pool_cnt          <= pool_cnt - 1'b1;
      end

      if (put_ok) begin
        valid_q[free_idx] <= 1'b1;
        pool_cnt          <= pool_cnt + 1'b1;
      end

      if (pend_we) begin
        stack_cnt <= stack_cnt + 1'b1;
      end

      if (cmd.fl_put) begin
        stack_cnt <= stack_cnt - 1'b1;
        if (pool_full) drop_q <= 1'b1;
      end
    end
  end

  a_pool_cnt_matches_valid: assert property (@(posedge clk) disable iff (rst)
    pool_cnt == bfbp_pkg::CNT_W'($countones(valid_q)))
    else $error("pool count disagrees with slot valid bits");

  a_stack_bounded: assert property (@(posedge clk) disable iff (rst)
    stack_cnt <= bfbp_pkg::PCNT_W'(bfbp_pkg::PENDING_DEPTH))
    else $error("pending stack overran its depth");

  a_put_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    put_ok |-> !valid_q[free_idx])
    else $error("buffer written over an occupied slot");

  a_flush_pops_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.fl_put |-> stack_cnt != '0)
    else $error("flush popped an empty stack");

endmodule

`default_nettype wire

// ----- rtl/bfbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfbp_ctrl: sequencing state machine of the buffer pool
// Accepts one transaction at a time, steps the datapath through scan, flush
// and update, and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbp_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bfbp_pkg::KIND_W-1:0] kind,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bfbp_pkg::cmd_t                   cmd,
  input  wire bfbp_pkg::stat_t             stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACQ,
    S_FL_RD,
    S_FL_PUT,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.scan     = (state == S_ACQ);
    cmd.fl_put   = (state == S_FL_PUT);
    cmd.exec     = (state == S_EXEC);
    cmd.load_out = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise valid with a fresh result, else drop it once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (bfbp_pkg::kind_t'(kind))
              bfbp_pkg::KIND_ACQUIRE: state <= S_ACQ;
              bfbp_pkg::KIND_FLUSH:   state <= stat.stack_empty ? S_EXEC : S_FL_RD;
              default:                state <= S_EXEC;
            endcase
          end
        end
        S_ACQ: begin
          if (stat.scan_done) state <= S_EXEC;
        end
        S_FL_RD: begin
          state <= S_FL_PUT;
        end
        S_FL_PUT: begin
          state <= stat.stack_last ? S_EXEC : S_FL_RD;
        end
        S_EXEC: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_result_waits_for_sink: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> state == S_DONE)
    else $error("result loaded over an untaken one");

  a_idle_only_when_accepting: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state != S_IDLE)
    else $error("accepted transaction was not started");

  a_load_raises_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded without raising valid");

endmodule

`default_nettype wire
